FILE: rtl/core/lctrs_pkg.sv
`timescale 1ns / 1ps
// lctrs_pkg: types, constants and helper functions for the LC tuner relay search
// used by lctrs_next and lc_tuner_relay_search; no dependencies
package lctrs_pkg;

	localparam int COARSE_STEPS = 11;
	localparam logic [4:0] COARSE_STEPS_W = 5'(COARSE_STEPS);

	// configuration register indexes
	localparam logic [1:0] CFG_MIN_POWER    = 2'd0;
	localparam logic [1:0] CFG_STOP_SWR     = 2'd1;
	localparam logic [1:0] CFG_MAX_SWR      = 2'd2;
	localparam logic [1:0] CFG_SETTLE_TICKS = 2'd3;

	localparam logic [15:0] MIN_POWER_RST    = 16'd10;
	localparam logic [13:0] STOP_SWR_RST     = 14'd120;
	localparam logic [13:0] MAX_SWR_RST      = 14'd999;
	localparam logic [7:0]  SETTLE_TICKS_RST = 8'd2;

	typedef enum logic [1:0] {
		PH_WAIT_POWER = 2'd0,
		PH_COARSE     = 2'd1,
		PH_FINE_SETUP = 2'd2,
		PH_FINE_WALK  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_RUNNING   = 2'd1,
		ST_POWER_LOW = 2'd2,
		ST_READY     = 2'd3
	} tune_status_t;

	typedef struct packed {
		logic        restart;
		logic [15:0] power;
		logic [13:0] swr;
	} tick_t;

	typedef struct packed {
		logic [6:0]   cap_relay_bits;
		logic [6:0]   ind_relay_bits;
		logic         cap_side;
		tune_status_t status;
		logic         relays_updated;
	} result_t;

	typedef struct packed {
		logic [15:0] min_power;
		logic [13:0] stop_swr;
		logic [13:0] max_swr;
		logic [7:0]  settle_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t       phase;
		tune_status_t status;
		logic [7:0]   settle_count;
		logic [3:0]   cap_index;
		logic [3:0]   ind_index;
		logic [13:0]  best_ratio;
		logic [3:0]   best_cap_index;
		logic [3:0]   best_ind_index;
		logic         best_side;
		logic [13:0]  row_best_ratio;
		logic [13:0]  prev_row_best_ratio;
		logic         side;
		logic [6:0]   cap_out;
		logic [6:0]   ind_out;
	} state_t;

	typedef logic [2:0][6:0] points_t;

	typedef struct packed {
		points_t cap_pts;
		points_t ind_pts;
	} fine_pts_t;

	function automatic logic [6:0] relay_tab(input logic [3:0] i);
		logic [6:0] v;
		case (i)
			4'd0:    v = 7'h00;
			4'd1:    v = 7'h01;
			4'd2:    v = 7'h02;
			4'd3:    v = 7'h04;
			4'd4:    v = 7'h08;
			4'd5:    v = 7'h10;
			4'd6:    v = 7'h20;
			4'd7:    v = 7'h40;
			4'd8:    v = 7'h60;
			4'd9:    v = 7'h70;
			default: v = 7'h7F;
		endcase
		return v;
	endfunction

	// x + x/20, with x/20 = (x>>2)/5 through a reciprocal multiply
	function automatic logic [14:0] plus5(input logic [13:0] x);
		logic [11:0] y;
		logic [23:0] prod;
		y = x[13:2];
		prod = 24'(y) * 24'd3277;
		return 15'(x) + 15'(prod[23:14]);
	endfunction

	function automatic logic [1:0] fix_index(input logic [3:0] i);
		return (i < 4'd3) ? i[1:0] : 2'd1;
	endfunction

	function automatic logic [6:0] pick3(input points_t p, input logic [1:0] i);
		logic [6:0] v;
		case (i)
			2'd0:    v = p[0];
			2'd2:    v = p[2];
			default: v = p[1];
		endcase
		return v;
	endfunction

	// low, middle and high fine points around coarse index b
	function automatic points_t make_points(input logic [3:0] b);
		logic [6:0] mid;
		logic [6:0] dl;
		logic [6:0] dh;
		points_t    p;
		mid = relay_tab(b);
		dl = 7'd0;
		dh = 7'd0;
		if (b != 4'd0) begin
			dl = (mid - relay_tab(b - 4'd1)) >> 1;
		end
		if ((5'(b) < (COARSE_STEPS_W - 5'd1)) && (b != 4'd15)) begin
			dh = (relay_tab(b + 4'd1) - mid) >> 1;
		end
		p[0] = mid - dl;
		p[1] = mid;
		p[2] = mid + dh;
		return p;
	endfunction

endpackage

FILE: rtl/core/lctrs_next.sv
`timescale 1ns / 1ps
// lctrs_next: per-tick next-state and result logic of the relay search
// depends on lctrs_pkg
module lctrs_next (
	input  lctrs_pkg::state_t    st,
	input  lctrs_pkg::fine_pts_t pts,
	input  lctrs_pkg::cfg_t      cfg,
	input  lctrs_pkg::tick_t     tk,
	output lctrs_pkg::state_t    st_nx,
	output lctrs_pkg::fine_pts_t pts_nx,
	output lctrs_pkg::result_t   res
);
	import lctrs_pkg::*;

	logic upd;

	always_comb begin
		logic [4:0]  c5;
		logic [4:0]  ind5;
		logic [13:0] rb;
		logic        done;
		logic [1:0]  cf;
		logic [1:0]  fi;
		logic        moved;
		st_nx = st;
		pts_nx = pts;
		upd = 1'b0;
		c5 = 5'd0;
		ind5 = 5'd0;
		rb = st.row_best_ratio;
		done = 1'b0;
		cf = 2'd1;
		fi = 2'd1;
		moved = 1'b0;
		if (tk.restart) begin
			st_nx.status = ST_IDLE;
			st_nx.phase = PH_WAIT_POWER;
			st_nx.side = 1'b0;
			st_nx.cap_out = 7'd0;
			st_nx.ind_out = 7'd0;
			upd = 1'b1;
			st_nx.settle_count = cfg.settle_ticks;
		end else if (st.status == ST_READY) begin
			st_nx = st;
		end else if (st.settle_count != 8'd0) begin
			st_nx.settle_count = st.settle_count - 8'd1;
		end else if ((st.phase != PH_WAIT_POWER) && (tk.power < cfg.min_power)) begin
			st_nx.status = ST_POWER_LOW;
		end else begin
			case (st.phase)
				PH_WAIT_POWER: begin
					if (tk.power >= cfg.min_power) begin
						st_nx.phase = PH_COARSE;
						st_nx.status = ST_RUNNING;
						st_nx.best_ratio = cfg.max_swr;
						st_nx.row_best_ratio = cfg.max_swr;
						st_nx.prev_row_best_ratio = cfg.max_swr;
						st_nx.cap_index = 4'd0;
						st_nx.ind_index = 4'd0;
						st_nx.settle_count = cfg.settle_ticks;
					end
				end
				PH_COARSE: begin
					if (tk.swr <= cfg.stop_swr) begin
						st_nx.status = ST_READY;
					end else begin
						rb = (tk.swr < st.row_best_ratio) ? tk.swr : st.row_best_ratio;
						st_nx.row_best_ratio = rb;
						if (tk.swr < st.best_ratio) begin
							st_nx.best_ratio = tk.swr;
							st_nx.best_cap_index = st.cap_index;
							st_nx.best_ind_index = st.ind_index;
							st_nx.best_side = st.side;
						end
						c5 = {1'b0, st.cap_index} + 5'd1;
						ind5 = {1'b0, st.ind_index};
						if ((c5 >= COARSE_STEPS_W) || ({1'b0, tk.swr} > plus5(rb))) begin
							c5 = 5'd0;
							ind5 = ind5 + 5'd1;
							// row more than 5% worse than the previous one: leave this side
							if (plus5(st.prev_row_best_ratio) < {1'b0, rb}) begin
								if (st.side) begin
									st_nx.cap_index = 4'd0;
									st_nx.ind_index = ind5[3:0];
									st_nx.phase = PH_FINE_SETUP;
									done = 1'b1;
								end else begin
									st_nx.side = 1'b1;
									ind5 = 5'd0;
									st_nx.prev_row_best_ratio = cfg.max_swr;
									st_nx.row_best_ratio = cfg.max_swr;
								end
							end else begin
								st_nx.prev_row_best_ratio = rb;
								st_nx.row_best_ratio = cfg.max_swr;
							end
							if (!done && (ind5 >= COARSE_STEPS_W)) begin
								ind5 = 5'd0;
								if (st_nx.side) begin
									st_nx.cap_index = 4'd0;
									st_nx.ind_index = 4'd0;
									st_nx.phase = PH_FINE_SETUP;
									done = 1'b1;
								end else begin
									st_nx.side = 1'b1;
								end
							end
						end
						if (!done) begin
							st_nx.cap_index = c5[3:0];
							st_nx.ind_index = ind5[3:0];
							st_nx.cap_out = relay_tab(c5[3:0]);
							st_nx.ind_out = relay_tab(ind5[3:0]);
							upd = 1'b1;
							st_nx.settle_count = cfg.settle_ticks;
						end
					end
				end
				PH_FINE_SETUP: begin
					st_nx.side = st.best_side;
					pts_nx.cap_pts = make_points(st.best_cap_index);
					pts_nx.ind_pts = make_points(st.best_ind_index);
					st_nx.best_ratio = cfg.max_swr;
					st_nx.best_cap_index = 4'd1;
					st_nx.best_ind_index = 4'd1;
					st_nx.cap_index = 4'd1;
					st_nx.ind_index = 4'd1;
					st_nx.cap_out = relay_tab(st.best_cap_index);
					st_nx.ind_out = relay_tab(st.best_ind_index);
					upd = 1'b1;
					st_nx.settle_count = cfg.settle_ticks;
					st_nx.phase = PH_FINE_WALK;
				end
				PH_FINE_WALK: begin
					cf = fix_index(st.cap_index);
					fi = fix_index(st.ind_index);
					if (tk.swr <= cfg.stop_swr) begin
						st_nx.status = ST_READY;
					end else begin
						if (tk.swr < st.best_ratio) begin
							st_nx.best_ratio = tk.swr;
							st_nx.best_cap_index = {2'b00, cf};
							st_nx.best_ind_index = {2'b00, fi};
						end
						if (cf == 2'd1) begin
							if (pts.cap_pts[0] != pts.cap_pts[1]) begin
								cf = 2'd0;
								moved = 1'b1;
							end else if (pts.cap_pts[2] != pts.cap_pts[1]) begin
								cf = 2'd2;
								moved = 1'b1;
							end
						end
						if (!moved && (cf == 2'd0) && (pts.cap_pts[2] != pts.cap_pts[1])) begin
							cf = 2'd2;
							moved = 1'b1;
						end
						if (!moved) begin
							cf = 2'd1;
							// inductor step continues from the low point to the high point
							if (fi == 2'd1) begin
								if (pts.ind_pts[0] != pts.ind_pts[1]) begin
									fi = 2'd0;
									moved = 1'b1;
								end else if (pts.ind_pts[2] != pts.ind_pts[1]) begin
									fi = 2'd2;
									moved = 1'b1;
								end
							end
							if (!moved && (fi == 2'd0) &&
							    (pts.ind_pts[2] != pts.ind_pts[1])) begin
								fi = 2'd2;
								moved = 1'b1;
							end
							if (!moved) begin
								fi = 2'd1;
							end
						end
						st_nx.cap_index = {2'b00, cf};
						st_nx.ind_index = {2'b00, fi};
						upd = 1'b1;
						if (!moved) begin
							st_nx.cap_out = pick3(pts.cap_pts, fix_index(st_nx.best_cap_index));
							st_nx.ind_out = pick3(pts.ind_pts, fix_index(st_nx.best_ind_index));
							st_nx.status = ST_READY;
						end else begin
							st_nx.cap_out = pick3(pts.cap_pts, cf);
							st_nx.ind_out = pick3(pts.ind_pts, fi);
							st_nx.settle_count = cfg.settle_ticks;
						end
					end
				end
				default: begin
					st_nx = st;
				end
			endcase
		end
	end

	always_comb begin
		res.cap_relay_bits = st_nx.cap_out;
		res.ind_relay_bits = st_nx.ind_out;
		res.cap_side = st_nx.side;
		res.status = st_nx.status;
		res.relays_updated = upd;
	end

endmodule

FILE: rtl/core/lc_tuner_relay_search.sv
`timescale 1ns / 1ps
// lc_tuner_relay_search: top level of the LC antenna tuner relay search
// depends on lctrs_pkg and lctrs_next
//
// One tick transaction in gives one result transaction out. A tick is
// registered, the search state is advanced by one pass of next-state logic,
// and the result lands in an output register; a new tick is taken every
// cycle, limited only by result_ready. The coarse search,
// fine 3x3 walk, settle countdown and power-low status all live in one state
// register updated once per tick. Configuration writes take effect at once
// and are meant to be done while no tick is in flight.
module lc_tuner_relay_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               tick_valid,
	output logic               tick_ready,
	input  lctrs_pkg::tick_t   tick,
	output logic               result_valid,
	input  logic               result_ready,
	output lctrs_pkg::result_t result
);
	import lctrs_pkg::*;

	cfg_t      cfg_q;
	state_t    state_q;
	state_t    st_nx;
	fine_pts_t pts_q;
	fine_pts_t pts_nx;
	tick_t     tick_s1;
	logic      valid_s1;
	result_t   res_nx;
	result_t   result_q;
	logic      result_valid_q;
	logic      advance;

	assign advance = valid_s1 && (!result_valid_q || result_ready);
	assign tick_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_power <= MIN_POWER_RST;
			cfg_q.stop_swr <= STOP_SWR_RST;
			cfg_q.max_swr <= MAX_SWR_RST;
			cfg_q.settle_ticks <= SETTLE_TICKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MIN_POWER:    cfg_q.min_power <= cfg_data;
				CFG_STOP_SWR:     cfg_q.stop_swr <= cfg_data[13:0];
				CFG_MAX_SWR:      cfg_q.max_swr <= cfg_data[13:0];
				CFG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data[7:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	lctrs_next u_next (
		.st     (state_q),
		.pts    (pts_q),
		.cfg    (cfg_q),
		.tk     (tick_s1),
		.st_nx  (st_nx),
		.pts_nx (pts_nx),
		.res    (res_nx)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_WAIT_POWER;
			state_q.status <= ST_IDLE;
			state_q.settle_count <= SETTLE_TICKS_RST;
			state_q.cap_index <= 4'd0;
			state_q.ind_index <= 4'd0;
			state_q.best_ratio <= 14'd0;
			state_q.best_cap_index <= 4'd0;
			state_q.best_ind_index <= 4'd0;
			state_q.best_side <= 1'b0;
			state_q.row_best_ratio <= 14'd0;
			state_q.prev_row_best_ratio <= 14'd0;
			state_q.side <= 1'b0;
			state_q.cap_out <= 7'd0;
			state_q.ind_out <= 7'd0;
		end else if (advance) begin
			state_q <= st_nx;
		end
	end

	// fine points, written on entering the fine grid
	always_ff @(posedge clk) begin
		if (advance) begin
			pts_q <= pts_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nx;
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && tick_s1.restart) |=>
		(result_q.status == ST_IDLE && result_q.relays_updated &&
		 result_q.cap_relay_bits == 7'd0 && result_q.ind_relay_bits == 7'd0))
		else $error("restart did not clear relays");

	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !tick_s1.restart && state_q.status == ST_READY) |=>
		(result_q.status == ST_READY && !result_q.relays_updated))
		else $error("ready state changed without restart");

	a_stage_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("tick lost in input stage");

	a_fine_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_FINE_WALK) |->
		(state_q.cap_index <= 4'd2 && state_q.ind_index <= 4'd2))
		else $error("fine walk index out of grid");

endmodule
